[rtl/aafbx_pkg.sv]
// Shared types and constants for the ALU, flags and branch execute block.
package aafbx_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
  localparam int unsigned DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] PC_REG = REG_IDX_W'(REG_COUNT - 1);
  localparam logic [REG_IDX_W-1:0] LR_REG = REG_IDX_W'(REG_COUNT - 2);

  // Return address offset and branch target scaling.
  localparam logic [DATA_W-1:0] PC_STEP = DATA_W'(4);

  typedef enum logic [4:0] {
    ACT_MOV    = 5'd0,
    ACT_MVN    = 5'd1,
    ACT_MOVW   = 5'd2,
    ACT_MOVT   = 5'd3,
    ACT_AND    = 5'd4,
    ACT_BIC    = 5'd5,
    ACT_ORR    = 5'd6,
    ACT_ORN    = 5'd7,
    ACT_EOR    = 5'd8,
    ACT_ADD    = 5'd9,
    ACT_ADC    = 5'd10,
    ACT_SBC    = 5'd11,
    ACT_SUB    = 5'd12,
    ACT_RSB    = 5'd13,
    ACT_MUL    = 5'd14,
    ACT_TST    = 5'd15,
    ACT_CMP    = 5'd16,
    ACT_LSL    = 5'd17,
    ACT_LSR    = 5'd18,
    ACT_ASR    = 5'd19,
    ACT_BRANCH = 5'd20
  } action_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_HS = 4'd2,
    COND_LO = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14
  } cond_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

endpackage

[rtl/arm_alu_flags_branch_execute.sv]
// Execute stage: ARM-style data processing, NZCV flags and conditional branches.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o   | action, dest, operands, set_flags,
//          |           |                        | condition, link, branch_target
//  out     | output    | out_valid_o/out_stall_i | result_value, write_done, flags_now,
//          |           |                        | branch_taken, pc_value
//
// Every item is held in the input register, is executed in a single pass of
// logic (adder, multiplier, shifter, condition check) and lands in the result register,
// so one item can be accepted in every cycle while the output does not stall.
// The register file and flags update at the same edge that loads the result register,
// so the next item sees them without any forwarding path.
// Reset clears the register file, the flags and both valid bits.
// A stall on the output holds the result register; the input register then holds its
// item and the input stalls only once that register is also full.
module arm_alu_flags_branch_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  action_i,
  input  logic [3:0]  dest_i,
  input  logic [31:0] first_operand_i,
  input  logic [31:0] second_operand_i,
  input  logic        set_flags_i,
  input  logic [3:0]  condition_i,
  input  logic        link_i,
  input  logic [7:0]  branch_target_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic        write_done_o,
  output logic [3:0]  flags_now_o,
  output logic        branch_taken_o,
  output logic [31:0] pc_value_o
);

  // Input register.
  logic                    s1_valid_q;
  aafbx_pkg::action_e      act_q;
  logic [3:0]              dest_q;
  logic [31:0]             a_q;
  logic [31:0]             b_q;
  logic                    setf_in_q;
  logic [3:0]              cond_q;
  logic                    link_q;
  logic [7:0]              target_q;

  // Architectural state.
  logic [31:0]             rf_q [aafbx_pkg::REG_COUNT];
  logic [31:0]             rf_d [aafbx_pkg::REG_COUNT];
  aafbx_pkg::flags_t       flags_q;
  aafbx_pkg::flags_t       flags_d;

  // Result register.
  logic                    out_valid_q;
  logic [31:0]             result_q;
  logic                    write_done_q;
  aafbx_pkg::flags_t       flags_out_q;
  logic                    taken_q;
  logic [31:0]             pc_out_q;

  logic                    advance;
  logic                    exec;
  logic                    in_accept;

  // The input register drains whenever the result register is free or being emptied.
  assign advance    = !out_valid_q || !out_stall_i;
  assign exec       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (exec) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q     <= aafbx_pkg::action_e'(action_i);
      dest_q    <= dest_i;
      a_q       <= first_operand_i;
      b_q       <= second_operand_i;
      setf_in_q <= set_flags_i;
      cond_q    <= condition_i;
      link_q    <= link_i;
      target_q  <= branch_target_i;
    end
  end

  // Shared adder for add, adc, sbc, sub, rsb and cmp.
  logic [31:0] add_x;
  logic [31:0] add_y;
  logic        add_cin;
  logic [32:0] sum;
  logic [31:0] sum_r;
  logic        sum_v;

  always_comb begin
    add_x   = a_q;
    add_y   = b_q;
    add_cin = 1'b0;
    case (act_q)
      aafbx_pkg::ACT_ADC: begin
        add_cin = flags_q.c;
      end
      aafbx_pkg::ACT_SBC: begin
        add_y   = ~b_q;
        add_cin = flags_q.c;
      end
      aafbx_pkg::ACT_SUB, aafbx_pkg::ACT_CMP: begin
        add_y   = ~b_q;
        add_cin = 1'b1;
      end
      aafbx_pkg::ACT_RSB: begin
        add_x   = b_q;
        add_y   = ~a_q;
        add_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'b0, add_cin};
  assign sum_r = sum[31:0];
  assign sum_v = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum_r[31]);

  // Shifter: amounts of 32 or more clear lsl and lsr and give the sign fill for asr.
  logic [7:0]  amt;
  logic        amt_big;
  logic [31:0] lsl_r;
  logic [31:0] lsr_r;
  logic [31:0] asr_r;

  assign amt     = b_q[7:0];
  assign amt_big = |amt[7:5];
  assign lsl_r   = amt_big ? 32'd0 : (a_q << amt[4:0]);
  assign lsr_r   = amt_big ? 32'd0 : (a_q >> amt[4:0]);
  assign asr_r   = amt_big ? {32{a_q[31]}} : 32'($signed(a_q) >>> amt[4:0]);

  logic [31:0] mul_r;
  assign mul_r = a_q * b_q;

  // Condition check against the flags in force before this item.
  logic cond_ok;
  always_comb begin
    unique case (cond_q)
      aafbx_pkg::COND_EQ: cond_ok = flags_q.z;
      aafbx_pkg::COND_NE: cond_ok = !flags_q.z;
      aafbx_pkg::COND_HS: cond_ok = flags_q.c;
      aafbx_pkg::COND_LO: cond_ok = !flags_q.c;
      aafbx_pkg::COND_MI: cond_ok = flags_q.n;
      aafbx_pkg::COND_PL: cond_ok = !flags_q.n;
      aafbx_pkg::COND_VS: cond_ok = flags_q.v;
      aafbx_pkg::COND_VC: cond_ok = !flags_q.v;
      aafbx_pkg::COND_HI: cond_ok = flags_q.c && !flags_q.z;
      aafbx_pkg::COND_LS: cond_ok = !flags_q.c || flags_q.z;
      aafbx_pkg::COND_GE: cond_ok = flags_q.n == flags_q.v;
      aafbx_pkg::COND_LT: cond_ok = flags_q.n != flags_q.v;
      aafbx_pkg::COND_GT: cond_ok = !flags_q.z && (flags_q.n == flags_q.v);
      aafbx_pkg::COND_LE: cond_ok = flags_q.z || (flags_q.n != flags_q.v);
      aafbx_pkg::COND_AL: cond_ok = 1'b1;
      default:            cond_ok = 1'b0;
    endcase
  end

  // Operation decode: result value, whether it is written, and the new flags.
  logic [31:0]       res;
  logic              wr;
  logic              setf;
  logic              nz_only;
  logic              use_sum;
  logic              taken;
  aafbx_pkg::flags_t fl;

  always_comb begin
    res     = 32'd0;
    wr      = 1'b1;
    setf    = 1'b0;
    nz_only = 1'b0;
    use_sum = 1'b0;
    taken   = 1'b0;
    unique case (act_q)
      aafbx_pkg::ACT_MOV: begin
        res = a_q; setf = setf_in_q; nz_only = 1'b1;
      end
      aafbx_pkg::ACT_MVN: begin
        res = ~a_q; setf = setf_in_q; nz_only = 1'b1;
      end
      aafbx_pkg::ACT_MOVW: res = {16'd0, b_q[15:0]};
      aafbx_pkg::ACT_MOVT: res = {b_q[15:0], rf_q[dest_q][15:0]};
      aafbx_pkg::ACT_AND: begin
        res = a_q & b_q; setf = setf_in_q;
      end
      aafbx_pkg::ACT_BIC: begin
        res = a_q & ~b_q; setf = setf_in_q;
      end
      aafbx_pkg::ACT_ORR: begin
        res = a_q | b_q; setf = setf_in_q;
      end
      aafbx_pkg::ACT_ORN: begin
        res = a_q | ~b_q; setf = setf_in_q;
      end
      aafbx_pkg::ACT_EOR: begin
        res = a_q ^ b_q; setf = setf_in_q;
      end
      aafbx_pkg::ACT_ADD, aafbx_pkg::ACT_ADC, aafbx_pkg::ACT_SBC,
      aafbx_pkg::ACT_SUB, aafbx_pkg::ACT_RSB: begin
        res = sum_r; setf = setf_in_q; use_sum = 1'b1;
      end
      aafbx_pkg::ACT_MUL: res = mul_r;
      aafbx_pkg::ACT_TST: begin
        // The flags follow a AND b, but nothing is written.
        res = a_q & b_q; wr = 1'b0; setf = 1'b1;
      end
      aafbx_pkg::ACT_CMP: begin
        res = sum_r; wr = 1'b0; setf = 1'b1; use_sum = 1'b1;
      end
      aafbx_pkg::ACT_LSL: begin
        res = lsl_r; setf = setf_in_q;
      end
      aafbx_pkg::ACT_LSR: begin
        res = lsr_r; setf = setf_in_q;
      end
      aafbx_pkg::ACT_ASR: begin
        res = asr_r; setf = setf_in_q;
      end
      aafbx_pkg::ACT_BRANCH: begin
        wr    = 1'b0;
        taken = cond_ok;
      end
      default: wr = 1'b0;
    endcase

    fl.n = res[31];
    fl.z = (res == 32'd0);
    fl.c = 1'b0;
    fl.v = 1'b0;
    if (nz_only) begin
      fl.c = flags_q.c;
      fl.v = flags_q.v;
    end else if (use_sum) begin
      fl.c = sum[32];
      fl.v = sum_v;
    end
  end

  assign flags_d = setf ? fl : flags_q;

  // Register file next state: data write, then the branch writes to PC and LR.
  logic [31:0] branch_pc;
  assign branch_pc = {22'd0, target_q, 2'b00};

  always_comb begin
    for (int i = 0; i < aafbx_pkg::REG_COUNT; i++) begin
      rf_d[i] = rf_q[i];
      if (wr && (dest_q == aafbx_pkg::REG_IDX_W'(i))) begin
        rf_d[i] = res;
      end
    end
    if (taken) begin
      if (link_q) begin
        rf_d[aafbx_pkg::LR_REG] = rf_q[aafbx_pkg::PC_REG] + aafbx_pkg::PC_STEP;
      end
      rf_d[aafbx_pkg::PC_REG] = branch_pc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aafbx_pkg::REG_COUNT; i++) begin
        rf_q[i] <= 32'd0;
      end
      flags_q <= '0;
    end else if (exec) begin
      for (int i = 0; i < aafbx_pkg::REG_COUNT; i++) begin
        rf_q[i] <= rf_d[i];
      end
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      result_q     <= wr ? res : 32'd0;
      write_done_q <= wr;
      flags_out_q  <= flags_d;
      taken_q      <= taken;
      pc_out_q     <= rf_d[aafbx_pkg::PC_REG];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign write_done_o   = write_done_q;
  assign flags_now_o    = flags_out_q;
  assign branch_taken_o = taken_q;
  assign pc_value_o     = pc_out_q;

  // A result that wrote no register always reports a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_done_o |-> result_value_o == 32'd0)
    else $error("result value nonzero without a register write");

  // A taken branch never writes a destination and leaves PC a word address below 1 KiB.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && branch_taken_o |->
      !write_done_o && pc_value_o[1:0] == 2'b00 && pc_value_o[31:10] == 22'd0)
    else $error("taken branch result inconsistent");

  // The input only stalls while an item is waiting in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // A freshly executed item reports the flags that the block now holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_o && flags_now_o == flags_q)
    else $error("reported flags differ from the flag register");

endmodule

[sim/arm_alu_flags_branch_execute_tb.sv]
// Self-checking testbench for the ARM-style ALU, flags and branch execute stage.
module arm_alu_flags_branch_execute_tb;
  import aafbx_pkg::*;

  // Codes that have no name in the package: the never-taken condition and the
  // range of spare action codes that execute as no operation.
  localparam logic [3:0] COND_NEVER      = 4'd15;
  localparam logic [4:0] ACT_FIRST_SPARE = 5'd21;
  localparam logic [4:0] ACT_LAST_SPARE  = 5'd31;

  // Cycles without any handshake on either channel before the run is declared hung.
  // The slowest legal stretch is a sender gap plus a receiver stall plus the pipeline,
  // so this limit leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Pipeline depth from input acceptance to result, used for the quiet tail.
  localparam int unsigned PIPE_LATENCY   = 2;
  localparam int unsigned MAX_REPORTS    = 200;

  // One instruction as it is presented on the input channel.
  typedef struct packed {
    logic [4:0]  action;
    logic [3:0]  dest;
    logic [31:0] first;
    logic [31:0] second;
    logic        set_flags;
    logic [3:0]  cond;
    logic        link;
    logic [7:0]  target;
  } exec_item_t;

  // Architectural outcome of one instruction as seen on the output channel.
  typedef struct packed {
    logic [31:0] value;
    logic        written;
    flags_t      flags;
    logic        taken;
    logic [31:0] pc;
  } exec_result_t;

  // An issued instruction, optionally with a hand-written outcome that replaces
  // the computed one.
  typedef struct packed {
    exec_item_t   item;
    logic         fixed;
    exec_result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [4:0]  action_i;
  logic [3:0]  dest_i;
  logic [31:0] first_operand_i;
  logic [31:0] second_operand_i;
  logic        set_flags_i;
  logic [3:0]  condition_i;
  logic        link_i;
  logic [7:0]  branch_target_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_value_o;
  logic        write_done_o;
  logic [3:0]  flags_now_o;
  logic        branch_taken_o;
  logic [31:0] pc_value_o;

  arm_alu_flags_branch_execute u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .dest_i           (dest_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .set_flags_i      (set_flags_i),
    .condition_i      (condition_i),
    .link_i           (link_i),
    .branch_target_i  (branch_target_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_value_o   (result_value_o),
    .write_done_o     (write_done_o),
    .flags_now_o      (flags_now_o),
    .branch_taken_o   (branch_taken_o),
    .pc_value_o       (pc_value_o)
  );

  // Architectural state mirrored by the testbench: register file and NZCV.
  logic [31:0] arch_regs [REG_COUNT];
  flags_t      arch_flags;

  // Instructions driven but not yet accepted, and outcomes still owed by the block.
  stim_row_t    issue_q [$];
  exec_result_t retire_q [$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned stall_left   = 0;
  // When set, neither side inserts gaps or stalls, so the pipeline runs back to back.
  bit          steady_mode  = 1'b0;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic exec_item_t mk_item(input logic [4:0] action, input logic [3:0] dest,
                                         input logic [31:0] first, input logic [31:0] second,
                                         input logic set_flags, input logic [3:0] cond,
                                         input logic link, input logic [7:0] target);
    exec_item_t it;
    it.action    = action;
    it.dest      = dest;
    it.first     = first;
    it.second    = second;
    it.set_flags = set_flags;
    it.cond      = cond;
    it.link      = link;
    it.target    = target;
    return it;
  endfunction

  function automatic exec_result_t mk_result(input logic [31:0] value, input logic written,
                                             input logic [3:0] flags, input logic taken,
                                             input logic [31:0] pc);
    exec_result_t res;
    res.value   = value;
    res.written = written;
    res.flags   = flags;
    res.taken   = taken;
    res.pc      = pc;
    return res;
  endfunction

  // N and Z of a result; C and V come back clear.
  function automatic flags_t nz_flags(input logic [31:0] r);
    flags_t f;
    f   = '0;
    f.n = r[31];
    f.z = (r == '0);
    return f;
  endfunction

  // a + b + carry-in with the ARM carry-out and signed overflow.
  function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                            input logic cin, output flags_t f);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    f   = nz_flags(sum[31:0]);
    f.c = sum[32];
    f.v = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  function automatic logic cond_holds(input logic [3:0] c, input flags_t f);
    case (c)
      COND_EQ: return f.z;
      COND_NE: return !f.z;
      COND_HS: return f.c;
      COND_LO: return !f.c;
      COND_MI: return f.n;
      COND_PL: return !f.n;
      COND_VS: return f.v;
      COND_VC: return !f.v;
      COND_HI: return f.c && !f.z;
      COND_LS: return !f.c || f.z;
      COND_GE: return f.n == f.v;
      COND_LT: return f.n != f.v;
      COND_GT: return !f.z && (f.n == f.v);
      COND_LE: return f.z || (f.n != f.v);
      COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Executes one instruction on the mirrored state and returns what the block
  // must report for it.
  function automatic exec_result_t arch_execute(input exec_item_t it);
    exec_result_t res;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  r;
    logic [7:0]   amt;
    flags_t       fl;
    logic         wr;
    logic         setf;
    logic         taken;
    a     = it.first;
    b     = it.second;
    amt   = b[7:0];
    r     = '0;
    fl    = '0;
    wr    = 1'b1;
    setf  = 1'b0;
    taken = 1'b0;
    case (it.action)
      ACT_MOV, ACT_MVN: begin
        r    = (it.action == ACT_MOV) ? a : ~a;
        setf = it.set_flags;
        // Moves only touch N and Z; carry and overflow survive.
        fl   = nz_flags(r);
        fl.c = arch_flags.c;
        fl.v = arch_flags.v;
      end
      ACT_MOVW: r = {16'd0, b[15:0]};
      ACT_MOVT: r = {b[15:0], arch_regs[it.dest][15:0]};
      ACT_AND:  begin r = a & b;  setf = it.set_flags; fl = nz_flags(r); end
      ACT_BIC:  begin r = a & ~b; setf = it.set_flags; fl = nz_flags(r); end
      ACT_ORR:  begin r = a | b;  setf = it.set_flags; fl = nz_flags(r); end
      ACT_ORN:  begin r = a | ~b; setf = it.set_flags; fl = nz_flags(r); end
      ACT_EOR:  begin r = a ^ b;  setf = it.set_flags; fl = nz_flags(r); end
      ACT_ADD:  begin r = add_carry(a, b, 1'b0, fl);          setf = it.set_flags; end
      ACT_ADC:  begin r = add_carry(a, b, arch_flags.c, fl);  setf = it.set_flags; end
      // Subtract with carry borrows NOT C, hence the plain carry as carry-in.
      ACT_SBC:  begin r = add_carry(a, ~b, arch_flags.c, fl); setf = it.set_flags; end
      ACT_SUB:  begin r = add_carry(a, ~b, 1'b1, fl);         setf = it.set_flags; end
      ACT_RSB:  begin r = add_carry(b, ~a, 1'b1, fl);         setf = it.set_flags; end
      ACT_MUL:  r = a * b;
      // Test and compare always set the flags and never write a register.
      ACT_TST: begin
        wr   = 1'b0;
        setf = 1'b1;
        fl   = nz_flags(a & b);
      end
      ACT_CMP: begin
        wr   = 1'b0;
        setf = 1'b1;
        r    = add_carry(a, ~b, 1'b1, fl);
      end
      ACT_LSL: begin
        r    = (amt >= 8'd32) ? '0 : a << amt;
        setf = it.set_flags;
        fl   = nz_flags(r);
      end
      ACT_LSR: begin
        r    = (amt >= 8'd32) ? '0 : a >> amt;
        setf = it.set_flags;
        fl   = nz_flags(r);
      end
      ACT_ASR: begin
        // Kept as separate statements so the shift stays arithmetic.
        if (amt >= 8'd32) r = {32{a[31]}};
        else              r = $signed(a) >>> amt;
        setf = it.set_flags;
        fl   = nz_flags(r);
      end
      ACT_BRANCH: begin
        wr    = 1'b0;
        taken = cond_holds(it.cond, arch_flags);
        if (taken) begin
          // The link register takes the old PC, so it is written first.
          if (it.link) arch_regs[LR_REG] = arch_regs[PC_REG] + PC_STEP;
          arch_regs[PC_REG] = 32'(it.target) * PC_STEP;
        end
      end
      default: wr = 1'b0;
    endcase
    if (wr) arch_regs[it.dest] = r;
    else    r = '0;
    if (setf) arch_flags = fl;
    res.value   = r;
    res.written = wr;
    res.flags   = arch_flags;
    res.taken   = taken;
    res.pc      = arch_regs[PC_REG];
    return res;
  endfunction

  // Operands lean on the values that stress carries, overflow and sign handling.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic exec_item_t random_item();
    exec_item_t  it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)       it.action = 5'($urandom_range(ACT_FIRST_SPARE, ACT_LAST_SPARE));
    else if (pick < 20) it.action = ACT_BRANCH;
    else                it.action = 5'($urandom_range(ACT_MOV, ACT_ASR));
    it.dest      = 4'($urandom_range(0, REG_COUNT - 1));
    it.first     = pick_operand();
    it.second    = pick_operand();
    it.set_flags = 1'($urandom_range(0, 1));
    it.cond      = 4'($urandom_range(COND_EQ, COND_NEVER));
    it.link      = 1'($urandom_range(0, 1));
    it.target    = 8'($urandom);
    // Shift amounts mostly land between 0 and 40, across the 32 boundary; the upper bits stay random
    // to show they are ignored.
    if (it.action inside {ACT_LSL, ACT_LSR, ACT_ASR} && $urandom_range(0, 3) != 0)
      it.second[7:0] = 8'($urandom_range(0, 40));
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: got %h, want %h", results_seen, what, got, want);
  endtask

  // Presents one instruction after a random gap (none in steady mode) and holds it until it is taken.
  // The payload only changes once the previous instruction has been accepted.
  task automatic send_item(input exec_item_t it, input logic fixed,
                           input exec_result_t want);
    stim_row_t   row;
    int unsigned gap;
    gap = steady_mode ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i         <= it.action;
    dest_i           <= it.dest;
    first_operand_i  <= it.first;
    second_operand_i <= it.second;
    set_flags_i      <= it.set_flags;
    condition_i      <= it.cond;
    link_i           <= it.link;
    branch_target_i  <= it.target;
    in_valid_i       <= 1'b1;
    row.item  = it;
    row.fixed = fixed;
    row.want  = want;
    issue_q.push_back(row);
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Drops valid and waits until every issued instruction has come back.
  task automatic wait_retired();
    in_valid_i <= 1'b0;
    while (issue_q.size() != 0 || retire_q.size() != 0) @(posedge clk_i);
  endtask

  // Monitor and receiver. Both channels are sampled at the rising edge, before any
  // nonblocking update of that edge lands, so accepted values are never ambiguous.
  // An accepted instruction is executed on the mirrored state right away, which keeps
  // the expected outcomes in issue order. The receiver draws a fresh stall length
  // after each accepted result, or none in steady mode.
  always @(posedge clk_i) begin
    stim_row_t    row;
    exec_result_t want;
    logic         in_acc;
    logic         out_acc;
    if (rst_ni) begin
      in_acc  = in_valid_i && !in_stall_o;
      out_acc = out_valid_o && !out_stall_i;
      if (in_acc && issue_q.size() != 0) begin
        row  = issue_q.pop_front();
        want = arch_execute(row.item);
        // Hand-written outcomes win; the mirrored state is still advanced above.
        if (row.fixed) want = row.want;
        retire_q.push_back(want);
      end
      if (out_acc) begin
        results_seen++;
        if (retire_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", result_value_o, '0);
        end else begin
          want = retire_q.pop_front();
          if (result_value_o !== want.value)
            report_mismatch("result_value", result_value_o, want.value);
          if (write_done_o !== want.written)
            report_mismatch("write_done", 32'(write_done_o), 32'(want.written));
          if (flags_now_o !== want.flags)
            report_mismatch("flags_now", 32'(flags_now_o), 32'(want.flags));
          if (branch_taken_o !== want.taken)
            report_mismatch("branch_taken", 32'(branch_taken_o), 32'(want.taken));
          if (pc_value_o !== want.pc)
            report_mismatch("pc_value", pc_value_o, want.pc);
        end
      end
      if (in_acc || out_acc) idle_cycles = 0;
      else                   idle_cycles++;
      if (out_acc)              stall_left = steady_mode ? 0 : $urandom_range(0, 5);
      else if (stall_left != 0) stall_left--;
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("arm_alu_flags_branch_execute verification failed");
    $finish;
  end

  initial begin
    stim_row_t directed [$];
    // Every input starts at a known value with reset asserted.
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    action_i         = ACT_MOV;
    dest_i           = '0;
    first_operand_i  = '0;
    second_operand_i = '0;
    set_flags_i      = 1'b0;
    condition_i      = COND_AL;
    link_i           = 1'b0;
    branch_target_i  = '0;
    for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
    arch_flags = '0;

    // Directed table. Rows whose outcome is plain from a reset state or an extreme
    // carry it typed in; the rest rely on the mirrored execution.
    // Extremes straight after reset: flag effects of moves and of the adder.
    directed.push_back('{item: mk_item(ACT_MOV, 4'd1, 32'hFFFF_FFFF, '0, 1'b1, COND_AL, 1'b0, '0),
      fixed: 1'b1, want: mk_result(32'hFFFF_FFFF, 1'b1, 4'b1000, 1'b0, '0)});
    directed.push_back('{item: mk_item(ACT_MVN, 4'd2, 32'hFFFF_FFFF, '0, 1'b1, COND_AL, 1'b0, '0),
      fixed: 1'b1, want: mk_result('0, 1'b1, 4'b0100, 1'b0, '0)});
    directed.push_back('{item: mk_item(ACT_ADD, 4'd3, 32'hFFFF_FFFF, 32'd1, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b1, want: mk_result('0, 1'b1, 4'b0110, 1'b0, '0)});
    directed.push_back('{item: mk_item(ACT_ADD, 4'd4, 32'h7FFF_FFFF, 32'd1, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b1, want: mk_result(32'h8000_0000, 1'b1, 4'b1001, 1'b0, '0)});
    // The never condition leaves PC alone; always links and jumps to the top target.
    directed.push_back('{item: mk_item(ACT_BRANCH, 4'd0, '0, '0, 1'b0, COND_NEVER, 1'b1, 8'hFF),
      fixed: 1'b1, want: mk_result('0, 1'b0, 4'b1001, 1'b0, '0)});
    directed.push_back('{item: mk_item(ACT_BRANCH, 4'd0, '0, '0, 1'b0, COND_AL, 1'b1, 8'hFF),
      fixed: 1'b1, want: mk_result('0, 1'b0, 4'b1001, 1'b1, 32'h0000_03FC)});
    // A spare action code with every other field but the condition at its maximum does nothing.
    directed.push_back('{item: mk_item(ACT_LAST_SPARE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, COND_AL, 1'b1, 8'hFF), fixed: 1'b1,
      want: mk_result('0, 1'b0, 4'b1001, 1'b0, 32'h0000_03FC)});
    // Move wide zero-extends and never touches the flags, even when asked to.
    directed.push_back('{item: mk_item(ACT_MOVW, 4'd5, '0, 32'hFFFF_FFFF, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b1, want: mk_result(32'h0000_FFFF, 1'b1, 4'b1001, 1'b0, 32'h0000_03FC)});
    directed.push_back('{item: mk_item(ACT_MOVT, 4'd5, '0, 32'h1234_ABCD, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_MUL, 4'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, COND_AL,
      1'b0, '0), fixed: 1'b0, want: '0});
    // Compare and test update the flags with set_flags low.
    directed.push_back('{item: mk_item(ACT_CMP, 4'd3, '0, 32'd1, 1'b0, COND_AL, 1'b0, '0),
      fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_TST, 4'd4, 32'h0000_00F0, 32'h0000_000F, 1'b0, COND_AL,
      1'b0, '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_SBC, 4'd7, '0, '0, 1'b1, COND_AL, 1'b0, '0),
      fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_ADC, 4'd8, 32'hFFFF_FFFF, '0, 1'b1, COND_AL, 1'b0, '0),
      fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_SUB, 4'd9, 32'h8000_0000, 32'd1, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_RSB, 4'd10, 32'd1, '0, 1'b1, COND_AL, 1'b0, '0),
      fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_AND, 4'd11, 32'hFFFF_0000, 32'h0F0F_0F0F, 1'b0, COND_AL,
      1'b0, '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_BIC, 4'd11, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1, COND_AL,
      1'b0, '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_ORR, 4'd12, 32'h8000_0000, 32'd1, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_ORN, 4'd12, '0, 32'hFFFF_FFFF, 1'b1, COND_AL, 1'b0, '0),
      fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_EOR, 4'd13, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      COND_AL, 1'b0, '0), fixed: 1'b0, want: '0});
    // Shift amounts: exactly 32, the largest in-range amount with junk above the
    // low byte, and the maximum byte for an arithmetic fill.
    directed.push_back('{item: mk_item(ACT_LSL, 4'd1, 32'hFFFF_FFFF, 32'd32, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_LSR, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FF1F, 1'b1, COND_AL,
      1'b0, '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_ASR, 4'd3, 32'h8000_0000, 32'h0000_00FF, 1'b1, COND_AL,
      1'b0, '0), fixed: 1'b0, want: '0});
    // A data op may write PC; the conditional link after it is not taken, as the move clears Z.
    directed.push_back('{item: mk_item(ACT_MOV, 4'd15, 32'h0000_0100, '0, 1'b1, COND_AL, 1'b0,
      '0), fixed: 1'b0, want: '0});
    directed.push_back('{item: mk_item(ACT_BRANCH, 4'd7, '0, '0, 1'b0, COND_EQ, 1'b1, 8'h10),
      fixed: 1'b0, want: '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_item(directed[i].item, directed[i].fixed, directed[i].want);

    // Random part in chunks. Every fourth chunk runs without gaps or stalls, and once
    // the sender holds off until the pipeline has fully drained.
    for (int chunk = 0; chunk < 10; chunk++) begin
      steady_mode = (chunk % 4 == 1);
      for (int k = 0; k < 100; k++) send_item(random_item(), 1'b0, '0);
      if (chunk == 4) wait_retired();
    end
    steady_mode = 1'b0;

    wait_retired();
    // Quiet tail: anything the block emits now has no expectation and is reported.
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    if (retire_q.size() != 0)
      report_mismatch("outcomes never delivered", 32'(retire_q.size()), '0);

    if (mismatches == 0) $display("arm_alu_flags_branch_execute verification clean");
    else                 $display("arm_alu_flags_branch_execute verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/aafbx_pkg.sv
rtl/arm_alu_flags_branch_execute.sv
sim/arm_alu_flags_branch_execute_tb.sv
